// File: rtl/core/mme_pkg.sv
`default_nettype none

package mme_pkg;

  // Fixed field widths of the ports.
  localparam int IDX_W       = 3;
  localparam int DIM_W       = 4;
  localparam int ELEM_IN_W   = 16;
  localparam int OUT_VALUE_W = 32;
  localparam int CFG_IDX_W   = 2;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_LOAD_A  = 2'd0,
    CMD_LOAD_B  = 2'd1,
    CMD_COMPUTE = 2'd2
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE     = 2'd0,
    S_WAIT_OUT = 2'd1,
    S_ISSUE    = 2'd2,
    S_DRAIN    = 2'd3
  } seq_state_t;

  // Control travelling alongside each pair of store reads.
  typedef struct packed {
    logic             vld;
    logic             first;
    logic             fin;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/mme_store.sv
`default_nettype none

module mme_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 16
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic signed [DW-1:0] wr_data,
  input  wire logic [AW-1:0]        rd_addr,
  output logic signed [DW-1:0]      rd_data
);

  logic signed [DW-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/mme_seq.sv
`default_nettype none

module mme_seq #(
  parameter int MAX_DIM = 8,
  parameter int AW      = 6
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [mme_pkg::DIM_W-1:0]   rows_a,
  input  wire logic [mme_pkg::DIM_W-1:0]   inner_dim,
  input  wire logic [mme_pkg::DIM_W-1:0]   cols_b,
  input  wire logic                        out_busy,
  input  wire logic                        mac_done,
  output logic                             busy,
  output logic [AW-1:0]                    a_addr,
  output logic [AW-1:0]                    b_addr,
  output mme_pkg::mac_ctl_t                ctl
);

  localparam int IW = mme_pkg::IDX_W;
  localparam int DW = mme_pkg::DIM_W;

  mme_pkg::seq_state_t state_r, state_nxt;
  logic [IW-1:0] r_r, r_nxt, c_r, c_nxt, k_r, k_nxt;
  logic [DW-1:0] nr_r, nr_nxt, nk_r, nk_nxt, nc_r, nc_nxt;
  logic          row_end, col_end, k_end, last_elem;

  // A dimension of zero acts as one; anything above the store size is clipped.
  function automatic logic [DW-1:0] dim_clamp(input logic [DW-1:0] d);
    logic [DW-1:0] res;
    res = d;
    if (d == '0) begin
      res = DW'(1);
    end else if (d > DW'(MAX_DIM)) begin
      res = DW'(MAX_DIM);
    end
    return res;
  endfunction

  assign row_end   = ({1'b0, r_r} == nr_r - DW'(1));
  assign col_end   = ({1'b0, c_r} == nc_r - DW'(1));
  assign k_end     = ({1'b0, k_r} == nk_r - DW'(1));
  assign last_elem = row_end && col_end;

  // Row of A and column of B addressed by the inner index.
  assign a_addr = AW'(r_r * MAX_DIM + k_r);
  assign b_addr = AW'(k_r * MAX_DIM + c_r);
  assign busy   = (state_r != mme_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r  <= r_nxt;
    c_r  <= c_nxt;
    k_r  <= k_nxt;
    nr_r <= nr_nxt;
    nk_r <= nk_nxt;
    nc_r <= nc_nxt;
  end

  // Walk result elements in row-major order, one inner step per cycle.
  always_comb begin
    state_nxt     = state_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    k_nxt         = k_r;
    nr_nxt        = nr_r;
    nk_nxt        = nk_r;
    nc_nxt        = nc_r;
    ctl           = '0;
    ctl.row       = r_r;
    ctl.col       = c_r;
    ctl.first     = (k_r == '0);
    ctl.fin       = k_end;
    ctl.last_elem = last_elem;
    case (state_r)
      mme_pkg::S_IDLE: begin
        if (start) begin
          nr_nxt    = dim_clamp(rows_a);
          nk_nxt    = dim_clamp(inner_dim);
          nc_nxt    = dim_clamp(cols_b);
          r_nxt     = '0;
          c_nxt     = '0;
          k_nxt     = '0;
          state_nxt = mme_pkg::S_WAIT_OUT;
        end
      end
      mme_pkg::S_WAIT_OUT: begin
        if (!out_busy) begin
          k_nxt     = '0;
          state_nxt = mme_pkg::S_ISSUE;
        end
      end
      mme_pkg::S_ISSUE: begin
        ctl.vld = 1'b1;
        if (k_end) begin
          state_nxt = mme_pkg::S_DRAIN;
        end else begin
          k_nxt = IW'(k_r + IW'(1));
        end
      end
      mme_pkg::S_DRAIN: begin
        if (mac_done) begin
          if (last_elem) begin
            state_nxt = mme_pkg::S_IDLE;
          end else begin
            if (col_end) begin
              c_nxt = '0;
              r_nxt = IW'(r_r + IW'(1));
            end else begin
              c_nxt = IW'(c_r + IW'(1));
            end
            state_nxt = mme_pkg::S_WAIT_OUT;
          end
        end
      end
      default: begin
        state_nxt = mme_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/mme_mac.sv
`default_nettype none

module mme_mac #(
  parameter int EW = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire mme_pkg::mac_ctl_t                      ctl,
  input  wire logic signed [EW-1:0]                   a_q,
  input  wire logic signed [EW-1:0]                   b_q,
  input  wire logic                                   out_stall,
  output logic                                        out_valid,
  output logic [mme_pkg::IDX_W-1:0]                   out_row,
  output logic [mme_pkg::IDX_W-1:0]                   out_col,
  output logic signed [mme_pkg::OUT_VALUE_W-1:0]      out_value,
  output logic                                        out_last,
  output logic                                        done
);

  localparam int PW  = 2 * EW;
  localparam int ACW = PW + 3;
  localparam int SW  = (ACW > mme_pkg::OUT_VALUE_W) ? ACW : mme_pkg::OUT_VALUE_W;
  localparam logic signed [SW-1:0] SAT_MAX = SW'(32'sh7FFF_FFFF);
  localparam logic signed [SW-1:0] SAT_MIN = SW'(32'sh8000_0000);

  mme_pkg::mac_ctl_t s1_ctl_r, s2_ctl_r;
  logic signed [PW-1:0]  prod_r;
  logic signed [ACW-1:0] acc_r, acc_nxt;
  logic signed [SW-1:0]  acc_wide;
  logic signed [mme_pkg::OUT_VALUE_W-1:0] sat_value;
  logic out_valid_r, out_valid_nxt;
  logic [mme_pkg::IDX_W-1:0] out_row_r, out_col_r;
  logic signed [mme_pkg::OUT_VALUE_W-1:0] out_value_r;
  logic out_last_r;

  // Control follows the store read and the product register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r    <= '0;
      s2_ctl_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_ctl_r    <= ctl;
      s2_ctl_r    <= s1_ctl_r;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Product of the two store words, registered before accumulation.
  always_ff @(posedge clk) begin
    prod_r <= a_q * b_q;
  end

  // Exact sum of the products, restarting on the first inner step.
  always_comb begin
    acc_nxt = s2_ctl_r.first ? ACW'(prod_r) : ACW'(acc_r + ACW'(prod_r));
  end

  // Saturate the finished sum to 32 bits.
  always_comb begin
    acc_wide = SW'(acc_nxt);
    if (acc_wide > SAT_MAX) begin
      sat_value = SAT_MAX[mme_pkg::OUT_VALUE_W-1:0];
    end else if (acc_wide < SAT_MIN) begin
      sat_value = SAT_MIN[mme_pkg::OUT_VALUE_W-1:0];
    end else begin
      sat_value = acc_wide[mme_pkg::OUT_VALUE_W-1:0];
    end
  end

  assign done = s2_ctl_r.vld && s2_ctl_r.fin;

  // The output register is loaded on the last inner step and freed by a beat.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ctl_r.vld) begin
      acc_r <= acc_nxt;
    end
    if (done) begin
      out_row_r   <= s2_ctl_r.row;
      out_col_r   <= s2_ctl_r.col;
      out_value_r <= sat_value;
      out_last_r  <= s2_ctl_r.last_elem;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// File: rtl/core/matrix_multiply_engine.sv
`default_nettype none

// Fixed-point matrix multiplier. Load beats write one signed element of A or B
// into one of two on-chip stores at row * MAX_DIM + column, one beat per cycle
// while in_stall is low; a load outside the store is dropped and so is the
// unused command code. A compute beat emits every element of A * B in row-major
// order with out_last on the final one, each the exact Q16.16 dot product
// saturated to 32 bits. Every element that a computation reads must have been
// loaded since reset. While a computation runs, in_stall is high. Each result
// element first waits to claim the output register, then takes one inner step
// per cycle through the shared store read ports and the single multiplier, then
// waits for the read and product stages to drain. Dimension registers read as
// zero are treated as one and values above MAX_DIM as MAX_DIM; write them only
// while the block is idle.

module matrix_multiply_engine #(
  parameter int MAX_DIM       = 8,
  parameter int ELEMENT_WIDTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [mme_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [mme_pkg::DIM_W-1:0]            cfg_data,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           in_command,
  input  wire logic [mme_pkg::IDX_W-1:0]            in_row_index,
  input  wire logic [mme_pkg::IDX_W-1:0]            in_col_index,
  input  wire logic signed [mme_pkg::ELEM_IN_W-1:0] in_element_value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic [mme_pkg::IDX_W-1:0]                 out_row,
  output logic [mme_pkg::IDX_W-1:0]                 out_col,
  output logic signed [mme_pkg::OUT_VALUE_W-1:0]    out_value,
  output logic                                      out_last
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW    = ELEMENT_WIDTH;
  localparam int DW    = mme_pkg::DIM_W;

  logic [DW-1:0] rows_a_r, inner_dim_r, cols_b_r;
  logic in_accept, in_range, start, a_we, b_we, store_we, seq_busy, mac_done;
  logic [AW-1:0] wr_addr, a_rd_addr, b_rd_addr;
  logic signed [EW-1:0] wr_data, a_q, b_q;
  mme_pkg::mac_ctl_t ctl;

  // Dimension registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r    <= DW'(8);
      inner_dim_r <= DW'(8);
      cols_b_r    <= DW'(8);
    end else if (cfg_we) begin
      case (mme_pkg::cfg_reg_t'(cfg_index))
        mme_pkg::CFG_ROWS_A:    rows_a_r    <= cfg_data;
        mme_pkg::CFG_INNER_DIM: inner_dim_r <= cfg_data;
        mme_pkg::CFG_COLS_B:    cols_b_r    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Command decode. Input is held off for the whole of a computation, so a
  // store write never meets a read of the same run.
  assign in_stall  = seq_busy;
  assign in_accept = in_valid && !in_stall;
  assign in_range  = ({1'b0, in_row_index} < (mme_pkg::IDX_W + 1)'(MAX_DIM)) &&
                     ({1'b0, in_col_index} < (mme_pkg::IDX_W + 1)'(MAX_DIM));

  always_comb begin
    a_we  = 1'b0;
    b_we  = 1'b0;
    start = 1'b0;
    case (mme_pkg::cmd_t'(in_command))
      mme_pkg::CMD_LOAD_A:  a_we  = in_accept && in_range;
      mme_pkg::CMD_LOAD_B:  b_we  = in_accept && in_range;
      mme_pkg::CMD_COMPUTE: start = in_accept;
      default: begin
      end
    endcase
  end

  assign store_we = a_we || b_we;
  assign wr_addr  = AW'(in_row_index * MAX_DIM + in_col_index);
  assign wr_data  = EW'($unsigned(in_element_value));

  mme_store #(.DEPTH(DEPTH), .AW(AW), .DW(EW)) u_a_store (
    .clk     (clk),
    .we      (a_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (a_rd_addr),
    .rd_data (a_q)
  );

  mme_store #(.DEPTH(DEPTH), .AW(AW), .DW(EW)) u_b_store (
    .clk     (clk),
    .we      (b_we),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (b_rd_addr),
    .rd_data (b_q)
  );

  mme_seq #(.MAX_DIM(MAX_DIM), .AW(AW)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .rows_a    (rows_a_r),
    .inner_dim (inner_dim_r),
    .cols_b    (cols_b_r),
    .out_busy  (out_valid && out_stall),
    .mac_done  (mac_done),
    .busy      (seq_busy),
    .a_addr    (a_rd_addr),
    .b_addr    (b_rd_addr),
    .ctl       (ctl)
  );

  mme_mac #(.EW(EW)) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .a_q       (a_q),
    .b_q       (b_q),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (out_last),
    .done      (mac_done)
  );

  // A finished sum must never land on a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> !$past(out_valid && out_stall))
    else $error("result written over a pending output beat");

  // Store reads are issued only during a computation.
  a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.vld |-> seq_busy)
    else $error("store read issued while idle");

  // No load may write a store while the inner loop reads it.
  a_no_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.vld |-> !store_we)
    else $error("store written during a computation");

endmodule

`default_nettype wire

// File: test/matrix_multiply_engine_test.sv
`timescale 1ns / 100ps

localparam int STORE_SIDE = 8;

// One element of the product matrix as it leaves the block.
typedef struct packed {
  logic [mme_pkg::IDX_W-1:0]              row;
  logic [mme_pkg::IDX_W-1:0]              col;
  logic signed [mme_pkg::OUT_VALUE_W-1:0] value;
  logic                                   last;
} gemm_elem_t;

// Keeps its own copy of both operand stores and the dimension registers,
// and turns every compute beat into the run of product elements it must give.
class gemm_scoreboard;
  logic signed [mme_pkg::ELEM_IN_W-1:0] a_mem [STORE_SIDE*STORE_SIDE];
  logic signed [mme_pkg::ELEM_IN_W-1:0] b_mem [STORE_SIDE*STORE_SIDE];
  logic [mme_pkg::DIM_W-1:0]            dim_regs [3];
  gemm_elem_t                           products_q [$];
  int                                   failures;

  function new();
    foreach (a_mem[i]) begin
      a_mem[i] = '0;
      b_mem[i] = '0;
    end
    foreach (dim_regs[i]) dim_regs[i] = 4'd8;
    failures = 0;
  endfunction

  // Zero counts as one and anything above the store side as the full side.
  static function int span(logic [mme_pkg::DIM_W-1:0] setting);
    if (setting == 0) return 1;
    if (setting > STORE_SIDE) return STORE_SIDE;
    return int'(setting);
  endfunction

  function void write_reg(mme_pkg::cfg_reg_t idx, logic [mme_pkg::DIM_W-1:0] value);
    dim_regs[int'(idx)] = value;
  endfunction

  function int pending();
    return products_q.size();
  endfunction

  // Exact sum of products in Q16.16, clipped to the 32-bit range.
  function logic signed [mme_pkg::OUT_VALUE_W-1:0] dot_product_sat(int r, int c, int n);
    longint acc;
    acc = 0;
    for (int k = 0; k < n; k++)
      acc += longint'(a_mem[r*STORE_SIDE+k]) * longint'(b_mem[k*STORE_SIDE+c]);
    if (acc > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (acc < -64'sd2147483648) return 32'sh8000_0000;
    return acc[31:0];
  endfunction

  function void note_beat(logic [1:0] cmd, logic [mme_pkg::IDX_W-1:0] row,
                          logic [mme_pkg::IDX_W-1:0] col,
                          logic signed [mme_pkg::ELEM_IN_W-1:0] value);
    int         nr;
    int         nk;
    int         nc;
    gemm_elem_t elem;
    nr = span(dim_regs[int'(mme_pkg::CFG_ROWS_A)]);
    nk = span(dim_regs[int'(mme_pkg::CFG_INNER_DIM)]);
    nc = span(dim_regs[int'(mme_pkg::CFG_COLS_B)]);
    case (cmd)
      mme_pkg::CMD_LOAD_A: a_mem[row*STORE_SIDE+col] = value;
      mme_pkg::CMD_LOAD_B: b_mem[row*STORE_SIDE+col] = value;
      mme_pkg::CMD_COMPUTE: begin
        for (int r = 0; r < nr; r++) begin
          for (int c = 0; c < nc; c++) begin
            elem.row   = r[mme_pkg::IDX_W-1:0];
            elem.col   = c[mme_pkg::IDX_W-1:0];
            elem.value = dot_product_sat(r, c, nk);
            elem.last  = (r == nr - 1) && (c == nc - 1);
            products_q.push_back(elem);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function void check_product(logic [mme_pkg::IDX_W-1:0] row,
                              logic [mme_pkg::IDX_W-1:0] col,
                              logic signed [mme_pkg::OUT_VALUE_W-1:0] value, logic last);
    gemm_elem_t want;
    if (products_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected product beat: row %0d col %0d value %0d last %0b",
                 row, col, value, last);
      return;
    end
    want = products_q.pop_front();
    if (want.row !== row || want.col !== col || want.value !== value ||
        want.last !== last) begin
      failures++;
      if (failures <= 10)
        $display("product mismatch: expected row %0d col %0d value %0d last %0b,",
                 want.row, want.col, want.value, want.last,
                 " got row %0d col %0d value %0d last %0b",
                 row, col, value, last);
    end
  endfunction
endclass

module matrix_multiply_engine_test;
  localparam int         WATCHDOG_LIMIT = 5000;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         RANDOM_BEATS   = 260;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;
  localparam int         IW             = mme_pkg::IDX_W;
  localparam int         EVW            = mme_pkg::ELEM_IN_W;
  localparam int         DMW            = mme_pkg::DIM_W;

  logic                                   clk = 1'b0;
  logic                                   rst_n;
  logic                                   cfg_we;
  logic [mme_pkg::CFG_IDX_W-1:0]          cfg_index;
  logic [DMW-1:0]                         cfg_data;
  logic                                   in_valid;
  logic                                   in_stall;
  logic [1:0]                             in_command;
  logic [IW-1:0]                          in_row_index;
  logic [IW-1:0]                          in_col_index;
  logic signed [EVW-1:0]                  in_element_value;
  logic                                   out_valid;
  logic                                   out_stall;
  logic [IW-1:0]                          out_row;
  logic [IW-1:0]                          out_col;
  logic signed [mme_pkg::OUT_VALUE_W-1:0] out_value;
  logic                                   out_last;

  gemm_scoreboard gemm_sb = new();

  // Which store entries have been written since reset.
  bit a_loaded [STORE_SIDE*STORE_SIDE];
  bit b_loaded [STORE_SIDE*STORE_SIDE];
  int rows_used;
  int inner_used;
  int cols_used;
  int beats_sent   = 0;
  bit calm         = 1'b0;
  bit hold_request = 1'b0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  matrix_multiply_engine u_dut (.*);

  // Every accepted beat on either side goes to the scoreboard; the watchdog
  // counts cycles in which neither side moves a beat.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        gemm_sb.note_beat(in_command, in_row_index, in_col_index, in_element_value);
      if (out_valid && !out_stall)
        gemm_sb.check_product(out_row, out_col, out_value, out_last);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 25);
    end
  end

  function automatic logic [EVW-1:0] pick_element();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return EVW'($urandom);
    endcase
  endfunction

  // Mostly small matrices, now and then zero, the full side or beyond it.
  function automatic logic [DMW-1:0] pick_dim_reg();
    int unsigned sel;
    sel = $urandom_range(0, 15);
    if (sel < 10) return DMW'($urandom_range(1, 3));
    if (sel < 12) return 4'd0;
    if (sel < 13) return 4'd8;
    if (sel < 14) return DMW'($urandom_range(9, 15));
    return DMW'($urandom_range(4, 7));
  endfunction

  // Offers one beat and returns at the edge where it is taken.
  task automatic send_beat(logic [1:0] cmd, logic [IW-1:0] row,
                           logic [IW-1:0] col, logic [EVW-1:0] value);
    if (!calm && $urandom_range(0, 99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_row_index     <= row;
    in_col_index     <= col;
    in_element_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd != CMD_UNUSED) beats_sent++;
  endtask

  task automatic load_elem(bit to_b, logic [IW-1:0] row, logic [IW-1:0] col,
                           logic [EVW-1:0] value);
    send_beat(to_b ? mme_pkg::CMD_LOAD_B : mme_pkg::CMD_LOAD_A, row, col, value);
    if (to_b) b_loaded[row*STORE_SIDE+col] = 1'b1;
    else a_loaded[row*STORE_SIDE+col] = 1'b1;
  endtask

  task automatic compute();
    send_beat(mme_pkg::CMD_COMPUTE, IW'($urandom), IW'($urandom), EVW'($urandom));
  endtask

  task automatic send_noise();
    send_beat(CMD_UNUSED, IW'($urandom), IW'($urandom), EVW'($urandom));
  endtask

  // Drops valid and waits until every product has arrived and the last
  // loads have had time to land in the stores.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (gemm_sb.pending() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_dims(logic [DMW-1:0] ra, logic [DMW-1:0] inner,
                              logic [DMW-1:0] cb);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= mme_pkg::CFG_ROWS_A;
    cfg_data  <= ra;
    @(posedge clk);
    cfg_index <= mme_pkg::CFG_INNER_DIM;
    cfg_data  <= inner;
    @(posedge clk);
    cfg_index <= mme_pkg::CFG_COLS_B;
    cfg_data  <= cb;
    @(posedge clk);
    cfg_we <= 1'b0;
    gemm_sb.write_reg(mme_pkg::CFG_ROWS_A, ra);
    gemm_sb.write_reg(mme_pkg::CFG_INNER_DIM, inner);
    gemm_sb.write_reg(mme_pkg::CFG_COLS_B, cb);
    rows_used  = gemm_sb.span(ra);
    inner_used = gemm_sb.span(inner);
    cols_used  = gemm_sb.span(cb);
  endtask

  // Loads every operand the next product reads that is still unwritten, and
  // rewrites a share of the others so that the content keeps changing.
  task automatic prepare_operands();
    for (int r = 0; r < rows_used; r++) begin
      for (int k = 0; k < inner_used; k++) begin
        if (!a_loaded[r*STORE_SIDE+k] || $urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 19) == 0) send_noise();
          load_elem(1'b0, IW'(r), IW'(k), pick_element());
        end
      end
    end
    for (int k = 0; k < inner_used; k++) begin
      for (int c = 0; c < cols_used; c++) begin
        if (!b_loaded[k*STORE_SIDE+c] || $urandom_range(0, 2) == 0) begin
          if ($urandom_range(0, 19) == 0) send_noise();
          load_elem(1'b1, IW'(k), IW'(c), pick_element());
        end
      end
    end
  endtask

  task automatic run_phase(logic [DMW-1:0] ra, logic [DMW-1:0] inner,
                           logic [DMW-1:0] cb, bit with_hold);
    int trailing;
    program_dims(ra, inner, cb);
    prepare_operands();
    compute();
    // The long hold-off starts here while loads keep being offered behind it.
    if (with_hold) hold_request = 1'b1;
    if (!with_hold && $urandom_range(0, 3) == 0) compute();
    if (with_hold) trailing = 6;
    else if ($urandom_range(0, 2) == 0) trailing = $urandom_range(1, 4);
    else trailing = 0;
    repeat (trailing)
      load_elem(1'($urandom_range(0, 1)), IW'($urandom), IW'($urandom), pick_element());
  endtask

  initial begin
    int directed_beats;
    int phase;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= mme_pkg::CFG_ROWS_A;
    cfg_data         <= '0;
    in_valid         <= 1'b0;
    in_command       <= mme_pkg::CMD_LOAD_A;
    in_row_index     <= '0;
    in_col_index     <= '0;
    in_element_value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Zero in every dimension register still gives a one-by-one product.
    program_dims(4'd0, 4'd0, 4'd0);
    load_elem(1'b0, 3'd0, 3'd0, 16'h8000);
    load_elem(1'b1, 3'd0, 3'd0, 16'h8000);
    compute();

    // Products of the most negative elements overflow the positive limit.
    program_dims(4'd1, 4'd3, 4'd1);
    for (int k = 0; k < 3; k++) begin
      load_elem(1'b0, 3'd0, IW'(k), 16'h8000);
      load_elem(1'b1, IW'(k), 3'd0, 16'h8000);
    end
    compute();

    // With B at its largest the same sum falls below the negative limit.
    for (int k = 0; k < 3; k++) load_elem(1'b1, IW'(k), 3'd0, 16'h7FFF);
    compute();

    // The unused command code is dropped, whatever its fields hold.
    send_beat(CMD_UNUSED, 3'd7, 3'd7, 16'hFFFF);

    // Far corner of both stores, then a single product of mixed extremes.
    load_elem(1'b0, 3'd7, 3'd7, 16'h7FFF);
    load_elem(1'b1, 3'd7, 3'd7, 16'h0000);
    program_dims(4'd1, 4'd1, 4'd1);
    compute();
    directed_beats = beats_sent;

    // Random phases; one full-size product meets the long result hold-off,
    // and a run of phases goes without any idling on either side.
    phase = 0;
    while (beats_sent < directed_beats + RANDOM_BEATS) begin
      calm = (phase >= 5) && (phase < 9);
      if (phase == 2) run_phase(4'd15, 4'd8, 4'd9, 1'b1);
      else run_phase(pick_dim_reg(), pick_dim_reg(), pick_dim_reg(), 1'b0);
      phase++;
    end
    calm = 1'b0;

    wait_idle();
    repeat (20) @(posedge clk);
    if (gemm_sb.failures == 0 && gemm_sb.pending() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
